// File: hdl/assert_macros.svh
// Assertion macros shared by the point window averaging RTL.
// Expects aclk and aresetn in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PWA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PWA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pwa_pkg.sv
// Package for the point window average / outlier gate.
// Holds the sequencer state type, register map and fixed field widths.
package pwa_pkg;

    localparam int WLEN_W  = 5;
    localparam int LIMIT_W = 34;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 64;

    localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [0:0] REG_OUTLIER_LIMIT = 1'b1;

    localparam logic [WLEN_W-1:0]  WLEN_RESET  = 5'd8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 34'd10000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_CHECK,
        ST_DONE
    } pwa_state_t;

endpackage

// File: hdl/pwa_div.sv
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// Signed dividend, unsigned nonzero divisor. Uses pwa_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pwa_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 5,
    parameter int QUO_W = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output logic signed [QUO_W-1:0] quo
);
    import pwa_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] mag_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   trial_sub;
    logic [NUM_W-1:0] res;

    assign trial     = {rem_reg, mag_reg[NUM_W-1]};
    assign ge        = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};
    assign res       = neg_reg ? (~mag_reg + NUM_W'(1)) : mag_reg;
    assign quo       = signed'(res[QUO_W-1:0]);
    assign done      = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
            neg_reg <= num[NUM_W-1];
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            mag_reg <= {mag_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    `PWA_ASSERT_NEXT(a_start_busy, start, busy_reg, "divider not busy after start")
    `PWA_ASSERT_NEXT(a_last_done, busy_reg && !start && cnt_reg == CNT_W'(NUM_W - 1),
                     done_reg && !busy_reg, "divider missed its final step")

endmodule

// File: hdl/point_window_average_outlier_gate_core.sv
// Top level of the point window average with outlier gate.
// Uses pwa_pkg, pwa_div and assert_macros.svh.
//
// Usage:
//   s_ channel: one point (x, y, z) per transfer. m_ channel: one result per
//   point, the truncated mean of the newest L window points and mean_valid.
//   L is window_length (0 acts as 1, clamped to MAX_WINDOW). Registers sit on
//   an APB port: window_length at 0x0, outlier_limit at 0x8, pready tied high.
//   Timing: one point at a time. A point takes two passes over the window
//   memory, one read per cycle, around a bit-serial divide of the three sums.
//   The memory read port sets the pass lengths, the divider the middle part.
//   The output register holds a result until taken; the next point is taken
//   as soon as the result is loaded there. If the receiver stalls and a new
//   result is ready, the block waits and holds s_ready low.
//   Reset: window reads as all-origin (a fill count masks unwritten entries),
//   registers return to 8 and 10000, no result pending. No clearing pass.
`include "assert_macros.svh"
module point_window_average_outlier_gate_core #(
    parameter int MAX_WINDOW = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_point_x,
    input  logic signed [COORD_BITS-1:0]  s_point_y,
    input  logic signed [COORD_BITS-1:0]  s_point_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_BITS-1:0]  m_mean_x,
    output logic signed [COORD_BITS-1:0]  m_mean_y,
    output logic signed [COORD_BITS-1:0]  m_mean_z,
    output logic                          m_mean_valid,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pwa_pkg::ADDR_W-1:0]    paddr,
    input  logic [pwa_pkg::DATA_W-1:0]    pwdata,
    output logic [pwa_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import pwa_pkg::*;

    localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int LW   = (CW > WLEN_W) ? CW : WLEN_W;
    localparam int SW   = COORD_BITS + $clog2(MAX_WINDOW);
    localparam int DW   = COORD_BITS + 1;
    localparam int QW   = 2 * DW;
    localparam int D2W  = QW + 2;
    localparam int CMPW = (D2W > LIMIT_W) ? D2W : LIMIT_W;
    localparam int PW   = 3 * COORD_BITS;

    // configuration
    logic [WLEN_W-1:0]  wlen_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg  <= WLEN_RESET;
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[ADDR_W-1])
                REG_WINDOW_LENGTH: wlen_reg  <= pwdata[WLEN_W-1:0];
                REG_OUTLIER_LIMIT: limit_reg <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[ADDR_W-1])
            REG_WINDOW_LENGTH: prdata = DATA_W'(wlen_reg);
            REG_OUTLIER_LIMIT: prdata = DATA_W'(limit_reg);
            default:           prdata = '0;
        endcase
    end

    // control state
    pwa_state_t       state_reg, state_next;
    logic [CW-1:0]    fill_reg;
    logic [CW-1:0]    len_reg;
    logic [CW-1:0]    issue_cnt_reg;
    logic [AW-1:0]    head_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic             p1_vld_reg, p2_vld_reg, p3_vld_reg;
    logic             m_valid_reg;

    logic             in_xfer, issue, issue_more, div_start, chk_start, out_load;
    logic             div_done;
    logic [AW-1:0]    wr_ptr;
    logic [LW-1:0]    wlen_ext;
    logic [CW-1:0]    len_sel;

    assign wlen_ext   = LW'(wlen_reg);
    assign len_sel    = (wlen_ext == '0) ? CW'(1) :
                        (wlen_ext > LW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : CW'(wlen_ext);
    assign wr_ptr     = (head_reg == AW'(MAX_WINDOW - 1)) ? '0 : head_reg + AW'(1);
    assign issue_more = issue_cnt_reg < len_reg;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        issue      = 1'b0;
        div_start  = 1'b0;
        chk_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                issue = issue_more;
                if (!issue_more && !p1_vld_reg) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    chk_start  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                issue = issue_more;
                if (!issue_more && !p1_vld_reg && !p2_vld_reg && !p3_vld_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_xfer = s_valid & s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            len_reg       <= '0;
            issue_cnt_reg <= '0;
            head_reg      <= '0;
            rd_ptr_reg    <= '0;
            p1_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
            p3_vld_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            p1_vld_reg <= issue;
            p2_vld_reg <= p1_vld_reg && (state_reg == ST_CHECK);
            p3_vld_reg <= p2_vld_reg;
            if (in_xfer) begin
                head_reg      <= wr_ptr;
                rd_ptr_reg    <= wr_ptr;
                len_reg       <= len_sel;
                issue_cnt_reg <= '0;
                if (fill_reg != CW'(MAX_WINDOW)) begin
                    fill_reg <= fill_reg + CW'(1);
                end
            end else if (chk_start) begin
                rd_ptr_reg    <= head_reg;
                issue_cnt_reg <= '0;
            end else if (issue) begin
                rd_ptr_reg    <= (rd_ptr_reg == '0) ? AW'(MAX_WINDOW - 1)
                                                    : rd_ptr_reg - AW'(1);
                issue_cnt_reg <= issue_cnt_reg + CW'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // window memory, newest entry at head_reg
    logic [PW-1:0] win_mem [0:MAX_WINDOW-1];
    logic [PW-1:0] rd_data_reg;
    logic          live_reg;

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            win_mem[wr_ptr] <= {s_point_x, s_point_y, s_point_z};
        end
        if (issue) begin
            rd_data_reg <= win_mem[rd_ptr_reg];
            live_reg    <= issue_cnt_reg < fill_reg;
        end
    end

    logic [PW-1:0]                 pt_word;
    logic signed [COORD_BITS-1:0]  pt_x, pt_y, pt_z;

    assign pt_word = live_reg ? rd_data_reg : '0;
    assign pt_x    = signed'(pt_word[PW-1 -: COORD_BITS]);
    assign pt_y    = signed'(pt_word[2*COORD_BITS-1 -: COORD_BITS]);
    assign pt_z    = signed'(pt_word[COORD_BITS-1:0]);

    // sums and divide
    logic signed [SW-1:0]         sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [COORD_BITS-1:0] mean_x, mean_y, mean_z;
    logic                         done_y, done_z;

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
        end else if (p1_vld_reg && state_reg == ST_SUM) begin
            sum_x_reg <= sum_x_reg + SW'(pt_x);
            sum_y_reg <= sum_y_reg + SW'(pt_y);
            sum_z_reg <= sum_z_reg + SW'(pt_z);
        end
    end

    pwa_div #(.NUM_W(SW), .DEN_W(CW), .QUO_W(COORD_BITS)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(sum_x_reg), .den(len_reg), .done(div_done), .quo(mean_x)
    );
    pwa_div #(.NUM_W(SW), .DEN_W(CW), .QUO_W(COORD_BITS)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(sum_y_reg), .den(len_reg), .done(done_y), .quo(mean_y)
    );
    pwa_div #(.NUM_W(SW), .DEN_W(CW), .QUO_W(COORD_BITS)) u_div_z (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(sum_z_reg), .den(len_reg), .done(done_z), .quo(mean_z)
    );

    // distance check: diff -> square -> sum and compare
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [QW-1:0] sx_reg, sy_reg, sz_reg;
    logic [D2W-1:0]       d2;
    logic                 ok_reg;

    assign d2 = D2W'($unsigned(sx_reg)) + D2W'($unsigned(sy_reg)) + D2W'($unsigned(sz_reg));

    always_ff @(posedge aclk) begin
        dx_reg <= DW'(pt_x) - DW'(mean_x);
        dy_reg <= DW'(pt_y) - DW'(mean_y);
        dz_reg <= DW'(pt_z) - DW'(mean_z);
        sx_reg <= QW'(dx_reg) * QW'(dx_reg);
        sy_reg <= QW'(dy_reg) * QW'(dy_reg);
        sz_reg <= QW'(dz_reg) * QW'(dz_reg);
        if (chk_start) begin
            ok_reg <= 1'b1;
        end else if (p3_vld_reg && (CMPW'(d2) >= CMPW'(limit_reg))) begin
            ok_reg <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_mean_x     <= mean_x;
            m_mean_y     <= mean_y;
            m_mean_z     <= mean_z;
            m_mean_valid <= ok_reg;
        end
    end

    assign m_valid = m_valid_reg;

    `PWA_ASSERT_NEXT(a_accept_sum, in_xfer, state_reg == ST_SUM, "accept did not start sum pass")
    `PWA_ASSERT_NOW(a_fill_max, 1'b1, fill_reg <= CW'(MAX_WINDOW), "fill count overflow")
    `PWA_ASSERT_NOW(a_issue_len, 1'b1, issue_cnt_reg <= len_reg, "read pass overran length")
    `PWA_ASSERT_NOW(a_div_lanes, div_done, done_y && done_z, "divider lanes out of step")
    `PWA_ASSERT_NEXT(a_load_valid, out_load, m_valid_reg, "result load lost")

endmodule

// File: dv/tb.sv
// Testbench for point_window_average_outlier_gate_core: window mean and outlier flag.
// Depends on pwa_pkg and the core RTL; a local predictor checks every result transfer.
`timescale 1ns / 100ps

module tb;

    localparam int MAX_WIN = 16;
    localparam int CW      = 16;

    localparam logic [pwa_pkg::ADDR_W-1:0] ADDR_WINDOW_LENGTH =
        {pwa_pkg::REG_WINDOW_LENGTH, 3'b000};
    localparam logic [pwa_pkg::ADDR_W-1:0] ADDR_OUTLIER_LIMIT =
        {pwa_pkg::REG_OUTLIER_LIMIT, 3'b000};
    localparam logic [pwa_pkg::LIMIT_W-1:0] LIMIT_MAX = '1;

    typedef struct {
        logic signed [CW-1:0] mx;
        logic signed [CW-1:0] my;
        logic signed [CW-1:0] mz;
        logic                 ok;
    } mean_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CW-1:0] s_point_x = '0;
    logic signed [CW-1:0] s_point_y = '0;
    logic signed [CW-1:0] s_point_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [CW-1:0] m_mean_x;
    logic signed [CW-1:0] m_mean_y;
    logic signed [CW-1:0] m_mean_z;
    logic m_mean_valid;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [pwa_pkg::ADDR_W-1:0] paddr = '0;
    logic [pwa_pkg::DATA_W-1:0] pwdata = '0;
    logic [pwa_pkg::DATA_W-1:0] prdata;
    logic pready;

    point_window_average_outlier_gate_core #(
        .MAX_WINDOW(MAX_WIN),
        .COORD_BITS(CW)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_point_x(s_point_x), .s_point_y(s_point_y), .s_point_z(s_point_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_mean_x(m_mean_x), .m_mean_y(m_mean_y), .m_mean_z(m_mean_z),
        .m_mean_valid(m_mean_valid),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 aclk = ~aclk;

    // Predictor state
    logic signed [CW-1:0] hist_x [MAX_WIN];
    logic signed [CW-1:0] hist_y [MAX_WIN];
    logic signed [CW-1:0] hist_z [MAX_WIN];
    logic [pwa_pkg::WLEN_W-1:0]  cfg_len   = pwa_pkg::WLEN_RESET;
    logic [pwa_pkg::LIMIT_W-1:0] cfg_limit = pwa_pkg::LIMIT_RESET;

    mean_result_t mean_expect_q [$];
    int  errors = 0;
    bit  gaps_on = 1'b0;
    int  stall_left = 0;

    initial begin
        for (int i = 0; i < MAX_WIN; i++) begin
            hist_x[i] = '0;
            hist_y[i] = '0;
            hist_z[i] = '0;
        end
    end

    initial begin
        #20_000_000;
        $display("[point_window_average_outlier_gate_core] ERROR");
        $finish;
    end

    function automatic mean_result_t average_window(logic [pwa_pkg::WLEN_W-1:0] len_raw,
                                                    logic [pwa_pkg::LIMIT_W-1:0] lim);
        int n;
        longint sx, sy, sz, ax, ay, az, dx, dy, dz, d2, lim_l;
        mean_result_t r;
        n = (len_raw == 0) ? 1 : ((len_raw > MAX_WIN) ? MAX_WIN : int'(len_raw));
        sx = 0;
        sy = 0;
        sz = 0;
        for (int i = 0; i < n; i++) begin
            sx += longint'(hist_x[i]);
            sy += longint'(hist_y[i]);
            sz += longint'(hist_z[i]);
        end
        ax = sx / n;
        ay = sy / n;
        az = sz / n;
        lim_l = longint'({30'b0, lim});
        r.ok = 1'b1;
        for (int i = 0; i < n; i++) begin
            dx = longint'(hist_x[i]) - ax;
            dy = longint'(hist_y[i]) - ay;
            dz = longint'(hist_z[i]) - az;
            d2 = dx * dx + dy * dy + dz * dz;
            if (d2 >= lim_l)
                r.ok = 1'b0;
        end
        r.mx = ax[CW-1:0];
        r.my = ay[CW-1:0];
        r.mz = az[CW-1:0];
        return r;
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[CW-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result sink: random stalls
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 39)
                                                     : $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge aclk) begin
        mean_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (mean_expect_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transfer: x=%0d y=%0d z=%0d valid=%0b",
                             m_mean_x, m_mean_y, m_mean_z, m_mean_valid);
            end else begin
                e = mean_expect_q.pop_front();
                if (m_mean_x !== e.mx || m_mean_y !== e.my || m_mean_z !== e.mz ||
                    m_mean_valid !== e.ok) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected x=%0d y=%0d z=%0d valid=%0b, got x=%0d y=%0d z=%0d valid=%0b",
                                 e.mx, e.my, e.mz, e.ok,
                                 m_mean_x, m_mean_y, m_mean_z, m_mean_valid);
                end
            end
        end
    end

    task automatic apb_access(input logic wr, input logic [pwa_pkg::ADDR_W-1:0] addr,
                              input logic [pwa_pkg::DATA_W-1:0] data,
                              output logic [pwa_pkg::DATA_W-1:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (wr) begin
            if (addr == ADDR_WINDOW_LENGTH)
                cfg_len = data[pwa_pkg::WLEN_W-1:0];
            else if (addr == ADDR_OUTLIER_LIMIT)
                cfg_limit = data[pwa_pkg::LIMIT_W-1:0];
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write, then read back and compare against the shadow copy
    task automatic set_register(input logic [pwa_pkg::ADDR_W-1:0] addr,
                                input logic [pwa_pkg::DATA_W-1:0] data);
        logic [pwa_pkg::DATA_W-1:0] rd;
        logic [pwa_pkg::DATA_W-1:0] want;
        apb_access(1'b1, addr, data, rd);
        apb_access(1'b0, addr, '0, rd);
        want = (addr == ADDR_WINDOW_LENGTH) ? pwa_pkg::DATA_W'(cfg_len)
                                            : pwa_pkg::DATA_W'(cfg_limit);
        if (rd !== want) begin
            errors++;
            if (errors <= 10)
                $display("register readback mismatch at 0x%0h: expected 0x%0h, got 0x%0h",
                         addr, want, rd);
        end
    endtask

    task automatic send_point(input logic signed [CW-1:0] px,
                              input logic signed [CW-1:0] py,
                              input logic signed [CW-1:0] pz);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_point_x <= px;
        s_point_y <= py;
        s_point_z <= pz;
        do @(posedge aclk); while (!s_ready);
        for (int i = MAX_WIN - 1; i > 0; i--) begin
            hist_x[i] = hist_x[i-1];
            hist_y[i] = hist_y[i-1];
            hist_z[i] = hist_z[i-1];
        end
        hist_x[0] = px;
        hist_y[0] = py;
        hist_z[0] = pz;
        mean_expect_q.insert(mean_expect_q.size(), average_window(cfg_len, cfg_limit));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (mean_expect_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic test_reset_defaults();
        logic [pwa_pkg::DATA_W-1:0] rd;
        apb_access(1'b0, ADDR_WINDOW_LENGTH, '0, rd);
        if (rd !== pwa_pkg::DATA_W'(pwa_pkg::WLEN_RESET)) begin
            errors++;
            $display("window_length after reset: expected %0d, got %0d",
                     pwa_pkg::WLEN_RESET, rd);
        end
        apb_access(1'b0, ADDR_OUTLIER_LIMIT, '0, rd);
        if (rd !== pwa_pkg::DATA_W'(pwa_pkg::LIMIT_RESET)) begin
            errors++;
            $display("outlier_limit after reset: expected %0d, got %0d",
                     pwa_pkg::LIMIT_RESET, rd);
        end
        // origin entries still count
        send_point(16'sd100, -16'sd100, 16'sd50);
        send_point(16'sd0, 16'sd0, 16'sd0);
        send_point(-16'sd1, -16'sd1, -16'sd1);
        wait_drained();
    endtask

    task automatic test_length_range();
        logic [pwa_pkg::WLEN_W-1:0] lens [5] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
        foreach (lens[k]) begin
            set_register(ADDR_WINDOW_LENGTH, 64'(lens[k]));
            send_point(16'sd300, 16'sd7, -16'sd9);
            send_point(-16'sd5, 16'sd1000, 16'sd3);
            wait_drained();
        end
    endtask

    task automatic test_coord_extremes();
        set_register(ADDR_WINDOW_LENGTH, 64'd16);
        set_register(ADDR_OUTLIER_LIMIT, 64'(LIMIT_MAX));
        send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_point(16'sh8000, 16'sh8000, 16'sh8000);
        send_point(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_point(16'sh8000, 16'sh7FFF, 16'sh8000);
        wait_drained();
        set_register(ADDR_OUTLIER_LIMIT, 64'd0);
        send_point(16'sd0, 16'sd0, 16'sd0);
        send_point(16'sh8000, 16'sh7FFF, -16'sd1);
        wait_drained();
    endtask

    task automatic test_truncation();
        set_register(ADDR_WINDOW_LENGTH, 64'd3);
        set_register(ADDR_OUTLIER_LIMIT, 64'd100000);
        send_point(-16'sd1, -16'sd2, 16'sd1);
        send_point(-16'sd1, -16'sd2, 16'sd2);
        send_point(16'sd0, -16'sd3, 16'sd2);
        send_point(-16'sd7, 16'sd5, -16'sd8);
        wait_drained();
    endtask

    task automatic test_outlier_threshold();
        set_register(ADDR_WINDOW_LENGTH, 64'd2);
        set_register(ADDR_OUTLIER_LIMIT, 64'd1);
        send_point(16'sd0, 16'sd0, 16'sd0);
        send_point(16'sd2, 16'sd0, 16'sd0);
        wait_drained();
        set_register(ADDR_OUTLIER_LIMIT, 64'd2);
        send_point(16'sd0, 16'sd0, 16'sd0);
        wait_drained();
        set_register(ADDR_WINDOW_LENGTH, 64'd4);
        set_register(ADDR_OUTLIER_LIMIT, 64'd100);
        send_point(16'sd1, 16'sd1, 16'sd1);
        send_point(16'sd2, 16'sd1, 16'sd0);
        send_point(16'sd900, 16'sd1, 16'sd1);
        wait_drained();
    endtask

    task automatic test_random_phases();
        int  r, spread, cx, cy, cz, n_items;
        logic [pwa_pkg::DATA_W-1:0] wdata;
        logic [pwa_pkg::LIMIT_W-1:0] lim;
        logic signed [CW-1:0] px, py, pz;
        for (int ph = 0; ph < 12; ph++) begin
            gaps_on = (ph % 4) != 3;
            r = $urandom_range(0, 99);
            wdata = {$urandom(), $urandom()};
            wdata[pwa_pkg::WLEN_W-1:0] = (r < 10) ? 5'd0 :
                                         (r < 20) ? 5'($urandom_range(17, 31)) :
                                         (r < 30) ? 5'd16 : 5'($urandom_range(1, 16));
            set_register(ADDR_WINDOW_LENGTH, wdata);
            spread = 1 << $urandom_range(0, 15);
            r = $urandom_range(0, 99);
            if (r < 8)
                lim = '0;
            else if (r < 14)
                lim = LIMIT_MAX;
            else if (r < 24)
                lim = 34'({$urandom(), $urandom()});
            else
                lim = 34'(longint'(spread) * longint'(spread) * $urandom_range(1, 8));
            wdata = {$urandom(), $urandom()};
            wdata[pwa_pkg::LIMIT_W-1:0] = lim;
            set_register(ADDR_OUTLIER_LIMIT, wdata);
            cx = int'($urandom_range(0, 65535)) - 32768;
            cy = int'($urandom_range(0, 65535)) - 32768;
            cz = int'($urandom_range(0, 65535)) - 32768;
            n_items = 150 + $urandom_range(0, 20);
            for (int k = 0; k < n_items; k++) begin
                if ($urandom_range(0, 99) < 15) begin
                    px = CW'($urandom());
                    py = CW'($urandom());
                    pz = CW'($urandom());
                end else begin
                    px = clamp_coord(cx + int'($urandom_range(0, 2 * spread)) - spread);
                    py = clamp_coord(cy + int'($urandom_range(0, 2 * spread)) - spread);
                    pz = clamp_coord(cz + int'($urandom_range(0, 2 * spread)) - spread);
                end
                send_point(px, py, pz);
                if ($urandom_range(0, 59) == 0)
                    wait_drained();
            end
            wait_drained();
        end
        gaps_on = 1'b0;
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);
        test_reset_defaults();
        gaps_on = 1'b1;
        test_length_range();
        test_coord_extremes();
        test_truncation();
        test_outlier_threshold();
        test_random_phases();
        wait_drained();
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("[point_window_average_outlier_gate_core] OK");
        else
            $display("[point_window_average_outlier_gate_core] ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/pwa_pkg.sv
hdl/pwa_div.sv
hdl/point_window_average_outlier_gate_core.sv
dv/tb.sv
